// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the scanner RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SARS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scanner assertion failed");

// Property must never hold outside reset.
`define SARS_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
    else $error("scanner assertion failed (never)");

`endif

// ===== rtl/core/sars_pkg.sv =====
// Types and constants for the star and raw string token scanner.
// No dependencies; imported by sars_step and the top level.
package sars_pkg;

  localparam int unsigned QuoteRun = 3;

  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChLbrace = 8'h7B;

  typedef enum logic [3:0] {
    ModeIdle           = 4'd0,
    ModeStart          = 4'd1,
    ModeStarAfter      = 4'd2,
    ModeHashes         = 4'd3,
    ModeOpenQuotes     = 4'd4,
    ModeMlBody         = 4'd5,
    ModeMlLineStart    = 4'd6,
    ModeMlCloseQuotes  = 4'd7,
    ModeMlCloseHashes  = 4'd8,
    ModeDqBody         = 4'd9,
    ModeDqEscHashes    = 4'd10,
    ModeDqEscChar      = 4'd11,
    ModeDqCloseHashes  = 4'd12
  } mode_e;

  typedef enum logic [2:0] {
    StSpace       = 3'd0,
    StOpen        = 3'd1,
    StEndsWith    = 3'd2,
    StEndedBefore = 3'd3,
    StReject      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KindBinary  = 2'd0,
    KindPostfix = 2'd1,
    KindString  = 2'd2
  } kind_e;

  // Control part of the scanner state.
  typedef struct packed {
    mode_e      mode;
    logic       saw_space;
    logic [2:0] allowed;
  } ctl_t;

  // One registered input item.
  typedef struct packed {
    logic [7:0] char_code;
    logic       scan_start;
    logic [2:0] valid_mask;
    logic       end_of_input;
  } item_t;

endpackage

// ===== rtl/core/sars_step.sv =====
// Next-state and result logic of the scanner for one item.
// Depends on sars_pkg; purely combinational.
module sars_step #(
  parameter int unsigned HASH_LIMIT = 15,
  parameter int unsigned CntW       = 4
) (
  input  sars_pkg::item_t   item_i,
  input  sars_pkg::ctl_t    ctl_i,
  input  logic [CntW-1:0]   hashes_i,
  input  logic [CntW-1:0]   progress_i,
  output sars_pkg::ctl_t    ctl_o,
  output logic [CntW-1:0]   hashes_o,
  output logic [CntW-1:0]   progress_o,
  output sars_pkg::status_e status_o,
  output sars_pkg::kind_e   kind_o
);
  import sars_pkg::*;

  localparam logic [CntW-1:0] HashMax   = CntW'(HASH_LIMIT);
  localparam logic [CntW-1:0] QuoteRunC = CntW'(QuoteRun);
  localparam logic [CntW-1:0] One       = CntW'(1);

  ctl_t            cur_ctl;
  logic [CntW-1:0] cur_dh, cur_rp, rp_inc;
  logic [7:0]      ch;
  logic            eof, is_space, may_bin, done_hash, done_quote;
  mode_e           ml_mode, dq_mode;
  logic            dq_fail, dq_finish;

  // A start flag drops any scan in progress.
  always_comb begin
    if (item_i.scan_start) begin
      cur_ctl.mode      = ModeStart;
      cur_ctl.saw_space = 1'b0;
      cur_ctl.allowed   = item_i.valid_mask;
      cur_dh            = '0;
      cur_rp            = '0;
    end else begin
      cur_ctl = ctl_i;
      cur_dh  = hashes_i;
      cur_rp  = progress_i;
    end
  end

  assign eof      = item_i.end_of_input;
  assign ch       = eof ? 8'h00 : item_i.char_code;
  assign is_space = (ch == ChSpace) || (ch == ChNl);
  assign may_bin  = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A)) ||
                    ((ch >= 8'h30) && (ch <= 8'h39)) || (ch == ChUscore) ||
                    (ch == ChDquote) || (ch == ChLparen) || (ch == ChLbrack) ||
                    (ch == ChLbrace);

  assign rp_inc     = cur_rp + One;
  assign done_hash  = (rp_inc >= cur_dh);
  assign done_quote = (rp_inc >= QuoteRunC);

  // Multi-line body: a newline arms the closing-delimiter check.
  assign ml_mode = (ch == ChNl) ? ModeMlLineStart : ModeMlBody;

  // Single-line body.
  always_comb begin
    dq_fail   = eof || (ch == ChNl);
    dq_finish = 1'b0;
    dq_mode   = ModeDqBody;
    if (ch == ChBslash) begin
      dq_mode = (cur_dh == '0) ? ModeDqEscChar : ModeDqEscHashes;
    end else if (ch == ChDquote) begin
      if (cur_dh == '0) begin
        dq_finish = 1'b1;
        dq_mode   = ModeIdle;
      end else begin
        dq_mode = ModeDqCloseHashes;
      end
    end
  end

  always_comb begin
    ctl_o      = cur_ctl;
    hashes_o   = cur_dh;
    progress_o = cur_rp;
    status_o   = StOpen;
    kind_o     = KindBinary;
    case (cur_ctl.mode)
      ModeStart: begin
        if (is_space) begin
          ctl_o.saw_space = 1'b1;
          status_o        = StSpace;
        end else if ((ch == ChStar) && (cur_ctl.allowed[1:0] != 2'b00)) begin
          ctl_o.mode = ModeStarAfter;
        end else if (cur_ctl.allowed[2] &&
                     ((ch == ChHash) || (ch == ChSquote) || (ch == ChDquote))) begin
          hashes_o   = '0;
          progress_o = '0;
          if (ch == ChHash) begin
            hashes_o   = One;
            ctl_o.mode = ModeHashes;
          end else if (ch == ChSquote) begin
            progress_o = One;
            ctl_o.mode = ModeOpenQuotes;
          end else begin
            ctl_o.mode = ModeDqBody;
          end
        end else begin
          ctl_o.mode = ModeIdle;
          status_o   = StReject;
        end
      end
      ModeStarAfter: begin
        if ((cur_ctl.saw_space && is_space) || (!cur_ctl.saw_space && may_bin)) begin
          kind_o = KindBinary;
        end else begin
          kind_o = KindPostfix;
        end
        ctl_o.mode = ModeIdle;
        status_o   = StEndedBefore;
      end
      ModeHashes: begin
        if (ch == ChHash) begin
          if (cur_dh == HashMax) begin
            ctl_o.mode = ModeIdle;
            status_o   = StReject;
          end else begin
            hashes_o = cur_dh + One;
          end
        end else if (ch == ChSquote) begin
          progress_o = One;
          ctl_o.mode = ModeOpenQuotes;
        end else if (ch == ChDquote) begin
          ctl_o.mode = ModeDqBody;
        end else begin
          ctl_o.mode = ModeIdle;
          status_o   = StReject;
        end
      end
      ModeOpenQuotes: begin
        if (ch == ChSquote) begin
          progress_o = rp_inc;
          if (done_quote) ctl_o.mode = ModeMlBody;
        end else begin
          ctl_o.mode = ModeIdle;
          status_o   = StReject;
        end
      end
      ModeMlBody, ModeMlLineStart, ModeMlCloseQuotes, ModeMlCloseHashes: begin
        if ((cur_ctl.mode == ModeMlLineStart) && (ch == ChSpace)) begin
          status_o = StOpen;
        end else if ((cur_ctl.mode == ModeMlLineStart) && (ch == ChSquote)) begin
          progress_o = One;
          ctl_o.mode = ModeMlCloseQuotes;
        end else if ((cur_ctl.mode == ModeMlCloseQuotes) && (ch == ChSquote)) begin
          progress_o = rp_inc;
          if (done_quote) begin
            if (cur_dh == '0) begin
              ctl_o.mode = ModeIdle;
              status_o   = StEndsWith;
              kind_o     = KindString;
            end else begin
              progress_o = '0;
              ctl_o.mode = ModeMlCloseHashes;
            end
          end
        end else if ((cur_ctl.mode == ModeMlCloseHashes) && (ch == ChHash)) begin
          progress_o = rp_inc;
          if (done_hash) begin
            ctl_o.mode = ModeIdle;
            status_o   = StEndsWith;
            kind_o     = KindString;
          end
        end else if (eof) begin
          ctl_o.mode = ModeIdle;
          status_o   = StReject;
        end else begin
          ctl_o.mode = ml_mode;
        end
      end
      ModeDqEscChar: begin
        if (eof || (ch == ChNl)) begin
          ctl_o.mode = ModeIdle;
          status_o   = StReject;
        end else begin
          ctl_o.mode = ModeDqBody;
        end
      end
      ModeDqBody, ModeDqEscHashes, ModeDqCloseHashes: begin
        if ((cur_ctl.mode != ModeDqBody) && (ch == ChHash)) begin
          progress_o = rp_inc;
          if (done_hash) begin
            if (cur_ctl.mode == ModeDqEscHashes) begin
              ctl_o.mode = ModeDqEscChar;
            end else begin
              ctl_o.mode = ModeIdle;
              status_o   = StEndsWith;
              kind_o     = KindString;
            end
          end
        end else if (dq_fail) begin
          ctl_o.mode = ModeIdle;
          status_o   = StReject;
        end else begin
          progress_o = '0;
          ctl_o.mode = dq_mode;
          if (dq_finish) begin
            status_o = StEndsWith;
            kind_o   = KindString;
          end
        end
      end
      default: begin
        ctl_o.mode = ModeIdle;
        status_o   = StReject;
      end
    endcase
  end

endmodule

// ===== rtl/core/star_and_raw_string_token_scanner_core.sv =====
// Star and raw string token scanner: one character per item, one result per item.
// Depends on sars_pkg, sars_step and assert_macros.svh.
//
// The block accepts one item every clock cycle while in_ready_o is high and
// returns exactly one result item for each. An accepted item lands in an input
// register. When the result slot is free, the scanner state machine and its
// two hash/quote counters are updated from it by single-pass logic, and the
// result is written to the output register. The output register holds a
// result while out_ready_i is low. The input register keeps taking items as
// long as the result in front of it can move, so throughput is one item per
// cycle while the output is not stalled, and stalls propagate back by one
// stage. HASH_LIMIT sets the longest accepted hash run and the width of the
// hash and progress counters. The state is cleared by reset and restarted by
// a scan start; there is no configuration port.
module star_and_raw_string_token_scanner_core #(
  parameter int unsigned HASH_LIMIT = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       scan_start_i,
  input  logic [2:0] valid_mask_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [1:0] token_kind_o
);
  import sars_pkg::*;

`include "assert_macros.svh"

  // Counters must hold the hash limit and the three-quote run.
  localparam int unsigned HashW = $clog2(HASH_LIMIT + 1);
  localparam int unsigned CntW  = (HashW > 2) ? HashW : 2;
  localparam logic [CntW-1:0] HashMax = CntW'(HASH_LIMIT);

  // Input register
  logic  in_v_q;
  item_t item_q;

  // Scanner state
  ctl_t            ctl_q, ctl_d;
  logic [CntW-1:0] dh_q, dh_d;
  logic [CntW-1:0] rp_q, rp_d;

  // Result register
  logic    out_v_q;
  status_e st_q, st_d;
  kind_e   kind_q, kind_d;

  logic adv;

  // Token-closing results, for the checks below
  logic tok_end_q;
  logic scan_end_d;

  // The item in the input register moves on when the result slot frees up.
  assign adv        = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.char_code    <= char_code_i;
      item_q.scan_start   <= scan_start_i;
      item_q.valid_mask   <= valid_mask_i;
      item_q.end_of_input <= end_of_input_i;
    end
  end

  sars_step #(
    .HASH_LIMIT(HASH_LIMIT),
    .CntW      (CntW)
  ) u_step (
    .item_i    (item_q),
    .ctl_i     (ctl_q),
    .hashes_i  (dh_q),
    .progress_i(rp_q),
    .ctl_o     (ctl_d),
    .hashes_o  (dh_d),
    .progress_o(rp_d),
    .status_o  (st_d),
    .kind_o    (kind_d)
  );

  // State and counters advance only when an item is retired.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.mode      <= ModeIdle;
      ctl_q.saw_space <= 1'b0;
      ctl_q.allowed   <= 3'b000;
      dh_q            <= '0;
      rp_q            <= '0;
    end else if (adv) begin
      ctl_q <= ctl_d;
      dh_q  <= dh_d;
      rp_q  <= rp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q   <= st_d;
      kind_q <= kind_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign status_o     = st_q;
  assign token_kind_o = kind_q;

  assign tok_end_q  = (st_q == StEndsWith) || (st_q == StEndedBefore);
  assign scan_end_d = (st_d == StReject) || (st_d == StEndsWith) || (st_d == StEndedBefore);

  // A token kind other than binary only comes with a finished token.
  `SARS_ASSERT(a_kind_only_on_end, clk_i, rst_ni, out_v_q && (kind_q != KindBinary) |-> tok_end_q)
  // Every rejection or finished token leaves the scanner idle.
  `SARS_ASSERT(a_idle_after_end, clk_i, rst_ni, adv && scan_end_d |=> (ctl_q.mode == ModeIdle))
  // The stored hash count never passes the limit.
  `SARS_ASSERT_NEVER(a_hash_bound, clk_i, rst_ni, dh_q > HashMax)

endmodule

// ===== bench/star_string_scan_checker.sv =====
// Checker for the star and raw string token scanner: watches both channels,
// predicts one result per accepted character item and compares in order.
// Depends on sars_pkg for the item, mode, status and kind types.
`timescale 1ns / 1ps

module star_string_scan_checker #(
  parameter int unsigned HashLimit = 15
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] char_code_i,
  input  logic       scan_start_i,
  input  logic [2:0] valid_mask_i,
  input  logic       end_of_input_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [2:0] status_i,
  input  logic [1:0] token_kind_i,
  output int         error_count_o,
  output int         backlog_o
);
  import sars_pkg::*;

  typedef struct packed {
    status_e status;
    kind_e   kind;
  } scan_result_t;

  scan_result_t expected_q[$];
  int           mismatches = 0;

  // Predicted scanner state
  mode_e       mode;
  logic        saw_sp;
  logic [2:0]  kinds_ok;
  int unsigned hashes;
  int unsigned progress;
  kind_e       emit_kind;

  function automatic logic is_ws(logic [7:0] c);
    return c == ChSpace || c == ChNl;
  endfunction

  function automatic logic binary_follower(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == ChUscore || c == ChDquote ||
           c == ChLparen || c == ChLbrack || c == ChLbrace;
  endfunction

  function automatic status_e abort_scan();
    mode = ModeIdle;
    return StReject;
  endfunction

  function automatic status_e end_string();
    mode      = ModeIdle;
    emit_kind = KindString;
    return StEndsWith;
  endfunction

  function automatic status_e multiline_text(logic [7:0] c, logic eof);
    if (eof) return abort_scan();
    if (c == ChNl) mode = ModeMlLineStart;
    else mode = ModeMlBody;
    return StOpen;
  endfunction

  function automatic status_e quoted_text(logic [7:0] c, logic eof);
    if (eof || c == ChNl) return abort_scan();
    progress = 0;
    if (c == ChBslash) begin
      if (hashes == 0) mode = ModeDqEscChar;
      else mode = ModeDqEscHashes;
    end else if (c == ChDquote) begin
      if (hashes == 0) return end_string();
      mode = ModeDqCloseHashes;
    end else begin
      mode = ModeDqBody;
    end
    return StOpen;
  endfunction

  function automatic scan_result_t scan_char(item_t it);
    logic [7:0] c;
    logic       eof;
    status_e    st;
    eof       = it.end_of_input;
    c         = eof ? 8'h00 : it.char_code;  // exhausted input matches nothing
    emit_kind = KindBinary;
    if (it.scan_start) begin
      mode     = ModeStart;
      saw_sp   = 1'b0;
      kinds_ok = it.valid_mask;
      hashes   = 0;
      progress = 0;
    end
    case (mode)
      ModeStart: begin
        if (!eof && is_ws(c)) begin
          saw_sp = 1'b1;
          st     = StSpace;
        end else if (c == ChStar && kinds_ok[1:0] != 2'b00) begin
          mode = ModeStarAfter;
          st   = StOpen;
        end else if (kinds_ok[2] && (c == ChHash || c == ChSquote || c == ChDquote)) begin
          if (c == ChHash) begin
            hashes = 1;
            if (hashes > HashLimit) st = abort_scan();
            else begin
              mode = ModeHashes;
              st   = StOpen;
            end
          end else if (c == ChSquote) begin
            progress = 1;
            mode     = ModeOpenQuotes;
            st       = StOpen;
          end else begin
            mode = ModeDqBody;
            st   = StOpen;
          end
        end else begin
          st = abort_scan();
        end
      end
      ModeStarAfter: begin
        // binary: spaced on both sides, or tight and followed by an operand
        if (saw_sp && is_ws(c)) emit_kind = KindBinary;
        else if (!saw_sp && binary_follower(c)) emit_kind = KindBinary;
        else emit_kind = KindPostfix;
        mode = ModeIdle;
        st   = StEndedBefore;
      end
      ModeHashes: begin
        if (c == ChHash) begin
          hashes++;
          if (hashes > HashLimit) st = abort_scan();
          else st = StOpen;
        end else if (c == ChSquote) begin
          progress = 1;
          mode     = ModeOpenQuotes;
          st       = StOpen;
        end else if (c == ChDquote) begin
          mode = ModeDqBody;
          st   = StOpen;
        end else begin
          st = abort_scan();
        end
      end
      ModeOpenQuotes: begin
        if (c == ChSquote) begin
          progress++;
          if (progress >= QuoteRun) mode = ModeMlBody;
          st = StOpen;
        end else begin
          st = abort_scan();
        end
      end
      ModeMlBody: st = multiline_text(c, eof);
      ModeMlLineStart: begin
        if (c == ChSpace) st = StOpen;
        else if (c == ChSquote) begin
          progress = 1;
          mode     = ModeMlCloseQuotes;
          st       = StOpen;
        end else begin
          st = multiline_text(c, eof);
        end
      end
      ModeMlCloseQuotes: begin
        if (c == ChSquote) begin
          progress++;
          if (progress >= QuoteRun && hashes == 0) st = end_string();
          else begin
            if (progress >= QuoteRun) begin
              progress = 0;
              mode     = ModeMlCloseHashes;
            end
            st = StOpen;
          end
        end else begin
          st = multiline_text(c, eof);
        end
      end
      ModeMlCloseHashes: begin
        if (c == ChHash) begin
          progress++;
          if (progress >= hashes) st = end_string();
          else st = StOpen;
        end else begin
          st = multiline_text(c, eof);
        end
      end
      ModeDqBody: st = quoted_text(c, eof);
      ModeDqEscHashes: begin
        if (c == ChHash) begin
          progress++;
          if (progress >= hashes) mode = ModeDqEscChar;
          st = StOpen;
        end else begin
          st = quoted_text(c, eof);
        end
      end
      ModeDqEscChar: begin
        if (eof || c == ChNl) st = abort_scan();
        else begin
          mode = ModeDqBody;
          st   = StOpen;
        end
      end
      ModeDqCloseHashes: begin
        if (c == ChHash) begin
          progress++;
          if (progress >= hashes) st = end_string();
          else st = StOpen;
        end else begin
          st = quoted_text(c, eof);
        end
      end
      default: st = abort_scan();
    endcase
    if (st != StEndsWith && st != StEndedBefore) emit_kind = KindBinary;
    return '{st, emit_kind};
  endfunction

  always @(posedge clk_i) begin
    scan_result_t want;
    if (!rst_ni) begin
      mode     = ModeIdle;
      saw_sp   = 1'b0;
      kinds_ok = 3'b000;
      hashes   = 0;
      progress = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d kind %0d", $time, status_i,
                   token_kind_i);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status_i);
            mismatches++;
          end
          if (token_kind_i !== want.kind) begin
            $display("%0t: token_kind expected %0d, got %0d", $time, want.kind,
                     token_kind_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(scan_char(item_t'{char_code_i, scan_start_i, valid_mask_i,
                                               end_of_input_i}));
    end
    backlog_o     <= expected_q.size();
    error_count_o <= mismatches;
  end

endmodule

// ===== bench/star_and_raw_string_token_scanner_core_tb.sv =====
// Testbench top for star_and_raw_string_token_scanner_core: builds the character
// stream, drives both handshakes and gives the verdict.
// Depends on sars_pkg, the scanner RTL and star_string_scan_checker.
`timescale 1ns / 1ps

module star_and_raw_string_token_scanner_core_tb;
  import sars_pkg::*;

  localparam int unsigned HashLimit  = 15;
  localparam int          CycleLimit = 200_000;
  localparam int          RandomChars = 600;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] char_code;
  logic       scan_start;
  logic [2:0] valid_mask;
  logic       end_of_input;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] status;
  logic [1:0] token_kind;

  int scan_errors;
  int scan_backlog;
  int cycles = 0;
  int phase  = 0;  // 0: receiver slow, 1: sender slow, 2: no idling

  // Character stream under construction; fresh marks the next item as a scan opener.
  item_t      char_stream[$];
  logic       fresh = 1'b0;
  logic [2:0] open_mask;

  always #5 clk_i = ~clk_i;

  star_and_raw_string_token_scanner_core #(
    .HASH_LIMIT(HashLimit)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_code_i    (char_code),
    .scan_start_i   (scan_start),
    .valid_mask_i   (valid_mask),
    .end_of_input_i (end_of_input),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .token_kind_o   (token_kind)
  );

  star_string_scan_checker #(
    .HashLimit(HashLimit)
  ) scan_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .char_code_i    (char_code),
    .scan_start_i   (scan_start),
    .valid_mask_i   (valid_mask),
    .end_of_input_i (end_of_input),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .token_kind_i   (token_kind),
    .error_count_o  (scan_errors),
    .backlog_o      (scan_backlog)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[star_and_raw_string_token_scanner_core] ERROR");
      $finish;
    end
  end

  task automatic begin_scan(logic [2:0] mask);
    fresh     = 1'b1;
    open_mask = mask;
  endtask

  // Mask is only sampled with a scan start; elsewhere it is random junk.
  task automatic put(logic [7:0] c, logic eof = 1'b0);
    item_t it;
    it.char_code    = c;
    it.scan_start   = fresh;
    it.valid_mask   = fresh ? open_mask : 3'($urandom);
    it.end_of_input = eof;
    fresh = 1'b0;
    char_stream.push_back(it);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic add_star_scan();
    logic [2:0] mask;
    mask = 3'($urandom);
    if (mask[1:0] == 2'b00 && $urandom_range(0, 9) != 0) mask[$urandom_range(0, 1)] = 1'b1;
    begin_scan(mask);
    repeat ($urandom_range(0, 2)) put(pick(" \n"));
    put(ChStar);
    if ($urandom_range(0, 11) == 0) put(8'($urandom), 1'b1);
    else if ($urandom_range(0, 5) == 0) put(8'($urandom));
    else put(pick(" \nazAZ09_\"([{)];*+"));
  endtask

  task automatic add_string_scan();
    int   n;
    logic multi;
    begin_scan(3'($urandom) | 3'b100);
    if ($urandom_range(0, 3) == 0) put(pick(" \n"));
    case ($urandom_range(0, 14))
      0:       n = HashLimit + 1;  // one hash too many
      1:       n = HashLimit;
      default: n = $urandom_range(0, 3);
    endcase
    multi = 1'($urandom);
    repeat (n) put(ChHash);
    if (multi) put_text("'''");
    else put(ChDquote);
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 9) == 0) put(8'($urandom));
      else if (multi) put(pick("abc '#\"\n\n'"));
      else if ($urandom_range(0, 4) == 0) begin
        // escape, sometimes one hash short so the backslash is plain text
        put(ChBslash);
        repeat ($urandom_range(n > 0 ? n - 1 : 0, n)) put(ChHash);
        put(pick("ab\"\\#\n"));
      end else begin
        put(pick("abcde xyz#'\\\""));
      end
    end
    case ($urandom_range(0, 9))
      0: put(8'($urandom), 1'b1);  // input runs out inside the string
      1: ;                          // left open: next scan restarts it
      default: begin
        if (multi) begin
          put(ChNl);
          repeat ($urandom_range(0, 2)) put(ChSpace);
          put_text("'''");
        end else begin
          put(ChDquote);
        end
        repeat (n) put(ChHash);
      end
    endcase
  endtask

  task automatic add_noise();
    case ($urandom_range(0, 3))
      0: begin
        begin_scan(3'b100);
        put_text("##a");  // hashes not followed by a quote
      end
      1: begin
        begin_scan(3'b111);
        put_text("''#");  // only two opening quotes
      end
      default: begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0) begin_scan(3'($urandom));
          put($urandom_range(0, 7) == 0 ? 8'h00 : 8'($urandom), $urandom_range(0, 7) == 0);
        end
      end
    endcase
  endtask

  // Receiver: ready toggles at random by phase; one long hold-off when phase 2
  // starts so the pipeline fills and in_ready drops.
  initial begin
    logic held_off;
    held_off = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (phase == 2 && !held_off) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (40) @(negedge clk_i);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= (phase == 0 ? 63 : phase == 1 ? 21 : 0));
      end
    end
  end

  initial begin
    int total;
    int send_idle;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    char_code    = 8'h00;
    scan_start   = 1'b0;
    valid_mask   = 3'b000;
    end_of_input = 1'b0;
    out_ready    = 1'b0;

    // Directed opening
    put(8'hFF);                       // character while idle: rejected
    begin_scan(3'b111); put_text(" *\n");       // spaced star: binary
    begin_scan(3'b001); put_text("*a");         // tight star before operand: binary
    begin_scan(3'b010); put_text("*)");         // postfix
    begin_scan(3'b011); put(ChStar); put(8'h5A, 1'b1);  // star at end of input
    begin_scan(3'b000); put(ChStar);            // no kind allowed
    begin_scan(3'b011); put(ChDquote);          // string not allowed
    begin_scan(3'b100); put_text("#x");         // hash not followed by quote
    begin_scan(3'b100); put_text("''x");        // too few opening quotes
    begin_scan(3'b100); put_text("\"\n");       // newline in single-line string
    begin_scan(3'b100); put_text("#\"\\#\"\"#"); // escaped quote, hash-closed string
    begin_scan(3'b100); put_text("\"a");        // left open, restarted below

    total = char_stream.size() + RandomChars;
    while (char_stream.size() < total) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: add_star_scan();
        7, 8, 9, 10, 11, 12, 13, 14, 15: add_string_scan();
        default: add_noise();
      endcase
    end

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int k = 0; k < char_stream.size(); k++) begin
      phase     = k * 3 / char_stream.size();
      send_idle = (phase == 0) ? 21 : (phase == 1) ? 63 : 0;
      while ($urandom_range(0, 99) < send_idle) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
      in_valid <= 1'b1;
      {char_code, scan_start, valid_mask, end_of_input} <= char_stream[k];
      do @(posedge clk_i); while (!in_ready);
      @(negedge clk_i);
    end
    in_valid <= 1'b0;

    while (scan_backlog != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);  // catch stray results after the drain
    if (scan_errors == 0) $display("[star_and_raw_string_token_scanner_core] OK");
    else $display("[star_and_raw_string_token_scanner_core] ERROR");
    $finish;
  end

endmodule
